[design/kpd_pkg.sv]
// Shared types, codes and key map of the keypad scan, debounce and PIN entry unit.
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  // Default sizes.
  localparam int QUEUE_SLOTS_DEF = 8;
  localparam int PIN_DIGITS_DEF  = 5;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd40;
  localparam int          COL_COUNT      = 3;
  localparam int          PIN_OUT_W      = 40;

  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;

  // Command codes.
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_EDGE   = 3'd1;
  localparam logic [2:0] CMD_PIN    = 3'd2;
  localparam logic [2:0] CMD_SINGLE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_PIN   = 3'd1;
  localparam logic [2:0] ST_MENU  = 3'd2;
  localparam logic [2:0] ST_KEY   = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  // Register indexes.
  localparam logic REG_DEBOUNCE = 1'b0;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] column_index;
    logic [3:0] row_hits;
  } kpd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  key_code;
    logic [39:0] pin_value;
    logic [31:0] activity_time;
    logic        key_taken;
    logic        queue_nonempty;
    logic        edge_accepted;
  } kpd_out_t;

  // Index of the lowest set row; only meaningful when some row is set.
  function automatic logic [1:0] kpd_low_row(input logic [3:0] rows);
    logic [1:0] r;
    r = 2'd3;
    if (rows[2]) r = 2'd2;
    if (rows[1]) r = 2'd1;
    if (rows[0]) r = 2'd0;
    return r;
  endfunction

  // Fixed map 123 / 456 / 789 / *0#.
  function automatic logic [7:0] kpd_key(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] k;
    k = 8'h00;
    case (row)
      2'd0: k = (col == 2'd0) ? 8'h31 : (col == 2'd1) ? 8'h32 : 8'h33;
      2'd1: k = (col == 2'd0) ? 8'h34 : (col == 2'd1) ? 8'h35 : 8'h36;
      2'd2: k = (col == 2'd0) ? 8'h37 : (col == 2'd1) ? 8'h38 : 8'h39;
      2'd3: k = (col == 2'd0) ? KEY_STAR : (col == 2'd1) ? 8'h30 : KEY_HASH;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[design/keypad_scan_debounce_pin_entry_unit.sv]
// Keypad scan with debounce, key queue and PIN entry: top level.
//
// Input items arrive on in_valid / in_data and are taken when in_stall is low.
// Each item (tick, column edge, PIN fetch, single key fetch or clear) yields
// exactly one result on out_valid / out_data, held until a cycle with
// out_stall low completes the transfer.
// The state is updated and the result is registered at the edge that accepts
// the item. One item is taken every cycle while in_stall is low; the whole
// step is a debounce subtract-and-compare, a lowest-row pick and one access of
// the key queue, whose front entry is read from its registered memory port.
// A two-entry output buffer lets one more item enter while a result is
// stalled; in_stall rises only when both entries are full.
// Reset (rst_n low, synchronous) clears the counters, empties the queue and
// the digit count and sets the debounce window to 40 ticks; the queue memory and
// the digit registers are not cleared, and no clearing pass is needed.
// The debounce window is written over the APB-style port; write it only while
// the block is idle, which the block itself does not enforce. pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_debounce_pin_entry_unit
  import kpd_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int PIN_DIGITS  = PIN_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire kpd_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output kpd_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PTR_W  = $clog2(QUEUE_SLOTS);
  localparam int CNT_W  = $clog2(PIN_DIGITS + 1);
  localparam int DIG_IW = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int PACK_W = 8 * PIN_DIGITS;
  localparam int EXT_W  = (PACK_W > PIN_OUT_W) ? PACK_W : PIN_OUT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIN_DIGITS - 1);

  // Configuration.
  logic [15:0] debounce_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DEBOUNCE) ? {16'd0, debounce_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_wr && (paddr[2] == REG_DEBOUNCE)) begin
      debounce_r <= pwdata[15:0];
    end
  end

  // State.
  logic [31:0]      time_r, time_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       digits_r [PIN_DIGITS];

  // Key queue memory with a registered read of the next front entry.
  logic [7:0]       ring_mem [QUEUE_SLOTS];
  logic [7:0]       rd_q;
  logic             byp_r;
  logic [7:0]       byp_data_r;
  logic [7:0]       front_key;

  // Output buffer.
  logic             out_valid_r, skid_valid_r;
  kpd_out_t         out_r, skid_r;
  logic             in_fire, out_fire;

  kpd_out_t         res;
  logic             push_en, dig_we, edge_ok;
  logic [7:0]       edge_key;
  logic [PTR_W-1:0] head_inc, tail_inc;
  logic             ring_empty, ring_full;
  logic [PACK_W-1:0] pack;
  logic [EXT_W-1:0]  pack_ext;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;

  assign front_key  = byp_r ? byp_data_r : rd_q;
  assign head_inc   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign ring_empty = (head_r == tail_r);
  assign ring_full  = (head_inc == tail_r);

  assign edge_ok = ((time_r - last_r) >= {16'd0, debounce_r})
                   && (32'(in_data.column_index) < 32'(COL_COUNT))
                   && (in_data.row_hits != 4'd0);
  assign edge_key = kpd_key(kpd_low_row(in_data.row_hits), in_data.column_index);

  // Packed PIN: first digit in the top byte; the last digit is the key just popped.
  always_comb begin
    pack = '0;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      pack[PACK_W-1-8*i -: 8] = (i == PIN_DIGITS - 1) ? front_key : digits_r[i];
    end
  end
  assign pack_ext = EXT_W'(pack);

  always_comb begin
    time_nxt = time_r;
    last_nxt = last_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    push_en  = 1'b0;
    dig_we   = 1'b0;
    res      = '0;
    if (in_fire) begin
      case (in_data.command)
        CMD_TICK: begin
          time_nxt = time_r + 32'd1;
        end
        CMD_EDGE: begin
          if (edge_ok) begin
            last_nxt          = time_r;
            res.edge_accepted = 1'b1;
            // A full queue drops the key but the press still counts.
            if (!ring_full) begin
              push_en  = 1'b1;
              head_nxt = head_inc;
            end
          end
        end
        CMD_PIN: begin
          if (!ring_empty) begin
            res.key_code      = front_key;
            res.key_taken     = 1'b1;
            res.activity_time = time_r;
            tail_nxt          = tail_inc;
            if (front_key == KEY_STAR) begin
              head_nxt   = '0;
              tail_nxt   = '0;
              cnt_nxt    = '0;
              res.status = ST_MENU;
            end else if (cnt_r == CNT_LAST) begin
              res.pin_value = pack_ext[PIN_OUT_W-1:0];
              head_nxt      = '0;
              tail_nxt      = '0;
              cnt_nxt       = '0;
              res.status    = ST_PIN;
            end else begin
              dig_we     = 1'b1;
              cnt_nxt    = cnt_r + CNT_W'(1);
              res.status = ST_DIGIT;
            end
          end
        end
        CMD_SINGLE: begin
          if (!ring_empty) begin
            res.key_code  = front_key;
            res.key_taken = 1'b1;
            tail_nxt      = tail_inc;
            res.status    = ST_KEY;
          end
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
    res.queue_nonempty = (head_nxt != tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      last_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      byp_r  <= 1'b0;
    end else begin
      time_r <= time_nxt;
      last_r <= last_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      // A push into the slot that becomes the front is not seen by the read yet.
      byp_r  <= push_en && (head_r == tail_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      ring_mem[head_r] <= edge_key;
    end
    rd_q       <= ring_mem[tail_nxt];
    byp_data_r <= edge_key;
    if (dig_we) begin
      digits_r[cnt_r[DIG_IW-1:0]] <= front_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // The spare entry only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("output spare entry full while output register empty");

  // Entry always completes before the digit count passes PIN_DIGITS - 1.
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("digit count out of range");

  // A clear transfer empties the queue and the digit count.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.command == CMD_CLEAR)) |=> ((head_r == tail_r) && (cnt_r == '0)))
    else $error("clear did not empty the queue and digits");

  // A transfer that pops a key must have found the queue nonempty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.key_taken) |-> !ring_empty)
    else $error("key popped from an empty queue");

endmodule

`default_nettype wire
